// File: src/round_robin_time_slice_scheduler_macros.svh
// Assertion macros for the round-robin time-slice scheduler.
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define RRTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrts: same-cycle check failed");

// Next-cycle implication, checked on clk, off while rst_n is low.
`define RRTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrts: next-cycle check failed");

`endif

// File: src/rrts_pkg.sv
// Shared constants and types for the round-robin time-slice scheduler.
package rrts_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int IDX_W         = $clog2(MAX_PROCESSES);
  localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);
  localparam int DATA_W        = 16;
  localparam int STAT_W        = 3;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SERVE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_RAN   = 3'd0;
  localparam logic [STAT_W-1:0] STAT_DONE  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_IDLE  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ADDED = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL  = 3'd4;

  // One ring entry.
  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] pid;
  } entry_t;

  // Outcome of one time slice.
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] rem;
  } slice_t;

endpackage

// File: src/rrts_ring_mem.sv
// Process ring storage: one write port, one registered read port.
module rrts_ring_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [rrts_pkg::IDX_W-1:0] wr_addr,
  input  rrts_pkg::entry_t          wr_data,
  input  logic [rrts_pkg::IDX_W-1:0] rd_addr,
  output rrts_pkg::entry_t          rd_data
);

  rrts_pkg::entry_t mem [rrts_pkg::MAX_PROCESSES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/rrts_slice_unit.sv
// Time-slice unit: one compare and one subtract against the quantum.
module rrts_slice_unit (
  input  logic [rrts_pkg::DATA_W-1:0] rem,
  input  logic [rrts_pkg::DATA_W-1:0] quantum,
  output rrts_pkg::slice_t           slice
);

  always_comb begin
    slice.done = (rem <= quantum);
    slice.rem  = slice.done ? '0 : (rem - quantum);
  end

endmodule

// File: src/round_robin_time_slice_scheduler.sv
// Top level of the round-robin time-slice scheduler: sequencer, ring and output stage.
//
//  channel | ports                              | beat contents
//  --------+------------------------------------+--------------------------------------
//  in      | in_tvalid in_tready in_tdata in_tuser | tdata: process_id, exec_time; tuser: op
//  out     | out_tvalid out_tready out_tdata out_tuser | tdata: process_id_res, remaining;
//          |                                    | tuser: status
//  cfg     | cfg_wr_en cfg_wr_data              | quantum
//
// Add: accept, then result load. Serve: accept, a scan of n ring entries (1..16),
// then result load; the ring RAM read port delivers one entry per cycle.
// in_tready is high only in IDLE; a finished result waits in the output
// register, so a new beat is taken while the previous result is stalled.
// rst_n (synchronous) empties the ring and sets quantum to 1; no clearing pass.
module round_robin_time_slice_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // quantum
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // [15:0] process_id, [31:16] exec_time
  input  logic        in_tuser,      // [0] op
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [15:0] process_id_res, [31:16] remaining
  output logic [2:0]  out_tuser      // [2:0] status
);

  localparam int IDX_W  = rrts_pkg::IDX_W;
  localparam int CNT_W  = rrts_pkg::CNT_W;
  localparam int DATA_W = rrts_pkg::DATA_W;
  localparam int STAT_W = rrts_pkg::STAT_W;

  // One-hot sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] pid;
  } res_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;     // entries in the ring
  logic [IDX_W-1:0]  pos_r, pos_nxt;     // where the next serve scan starts
  logic [IDX_W-1:0]  idx_r, idx_nxt;     // entry under inspection
  logic [CNT_W-1:0]  k_r, k_nxt;         // entries inspected so far
  logic [DATA_W-1:0] quantum_r;
  res_t              res_r, res_nxt;
  logic              out_valid_r;
  res_t              out_r;

  logic              in_acc;
  logic [IDX_W-1:0]  start_idx;
  logic [CNT_W-1:0]  idx_p1;
  logic [IDX_W-1:0]  idx_wrap;
  logic              out_free;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  rrts_pkg::entry_t  wr_data;
  logic [IDX_W-1:0]  rd_addr;
  rrts_pkg::entry_t  rd_data;
  rrts_pkg::slice_t  slice;

  rrts_ring_mem u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // the one compare/subtract unit, fed by the entry the scan just read
  rrts_slice_unit u_slice (
    .rem     (rd_data.rem),
    .quantum (quantum_r),
    .slice   (slice)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // scan start; pos_r normally sits below cnt_r already
  assign start_idx = (CNT_W'(pos_r) >= cnt_r) ? '0 : pos_r;
  // ring successor of the inspected entry
  assign idx_p1    = CNT_W'(idx_r) + CNT_W'(1);
  assign idx_wrap  = (idx_p1 >= cnt_r) ? '0 : idx_p1[IDX_W-1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = '{rem: slice.rem, pid: rd_data.pid};
    rd_addr   = idx_r;
    case (state_r)
      ST_IDLE: begin
        rd_addr = start_idx;  // first entry of a serve scan comes out next cycle
        if (in_acc) begin
          if (in_tuser == rrts_pkg::OP_ADD) begin
            if (cnt_r == CNT_W'(rrts_pkg::MAX_PROCESSES)) begin
              res_nxt = '{status: rrts_pkg::STAT_FULL, rem: '0, pid: '0};
            end else begin
              wr_en   = 1'b1;
              wr_addr = cnt_r[IDX_W-1:0];
              wr_data = '{rem: in_tdata[31:16], pid: in_tdata[15:0]};
              cnt_nxt = cnt_r + CNT_W'(1);
              res_nxt = '{status: rrts_pkg::STAT_ADDED, rem: in_tdata[31:16],
                          pid: in_tdata[15:0]};
            end
            state_nxt = ST_LOAD;
          end else if (cnt_r == '0) begin
            res_nxt   = '{status: rrts_pkg::STAT_IDLE, rem: '0, pid: '0};
            pos_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            pos_nxt   = start_idx;
            idx_nxt   = start_idx;
            k_nxt     = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_addr = idx_wrap;  // prefetch the successor
        if (rd_data.rem != '0) begin
          // pending entry: take one slice and write it back
          wr_en     = 1'b1;
          wr_addr   = idx_r;
          res_nxt   = '{status: slice.done ? rrts_pkg::STAT_DONE : rrts_pkg::STAT_RAN,
                        rem: slice.rem, pid: rd_data.pid};
          pos_nxt   = idx_wrap;
          state_nxt = ST_LOAD;
        end else if (k_r + CNT_W'(1) >= cnt_r) begin
          // whole ring inspected, nothing pending
          res_nxt   = '{status: rrts_pkg::STAT_IDLE, rem: '0, pid: '0};
          state_nxt = ST_LOAD;
        end else begin
          idx_nxt = idx_wrap;
          k_nxt   = k_r + CNT_W'(1);
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pos_r       <= '0;
      idx_r       <= '0;
      k_r         <= '0;
      quantum_r   <= DATA_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      idx_r   <= idx_nxt;
      k_r     <= k_nxt;
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
      if (state_r == ST_LOAD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (state_r == ST_LOAD && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.rem, out_r.pid};
  assign out_tuser  = out_r.status;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "round_robin_time_slice_scheduler_macros.svh"

  `RRTS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(rrts_pkg::MAX_PROCESSES))
  `RRTS_ASSERT_NOW(a_pos_in_ring, cnt_r != '0, CNT_W'(pos_r) < cnt_r)
  `RRTS_ASSERT_NEXT(a_add_grows,
    in_acc && in_tuser == rrts_pkg::OP_ADD && cnt_r != CNT_W'(rrts_pkg::MAX_PROCESSES),
    cnt_r == $past(cnt_r) + CNT_W'(1))
  `RRTS_ASSERT_NEXT(a_scan_keeps_cnt, state_r == ST_SCAN, $stable(cnt_r))

endmodule

// File: verif/round_robin_time_slice_scheduler_checker.sv
`timescale 1ns / 1ps
// Channel monitor for the scheduler: predicts each result beat and compares it.
module round_robin_time_slice_scheduler_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,      // [15:0] process_id, [31:16] exec_time
  input  logic        in_tuser,      // [0] op
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,     // [15:0] process_id_res, [31:16] remaining
  input  logic [2:0]  out_tuser,     // [2:0] status
  output int          mismatches,
  output int          outstanding,
  output int          added_seen,
  output int          full_seen,
  output int          ran_seen,
  output int          done_seen,
  output int          idle_seen
);

  typedef struct packed {
    logic [rrts_pkg::DATA_W-1:0] pid;
    logic [rrts_pkg::DATA_W-1:0] rem;
    logic [rrts_pkg::STAT_W-1:0] status;
  } slice_report_t;

  // Shadow of the ring, the serve cursor and the quantum register.
  rrts_pkg::entry_t            ring [rrts_pkg::MAX_PROCESSES];
  int                          ring_len;
  int                          cursor;
  logic [rrts_pkg::DATA_W-1:0] quantum;
  slice_report_t               awaited_reports [$];

  function automatic slice_report_t schedule_item(
      input logic                        op,
      input logic [rrts_pkg::DATA_W-1:0] pid,
      input logic [rrts_pkg::DATA_W-1:0] etime);
    slice_report_t r;
    int            slot;
    int            k;
    bit            found;
    r.pid    = '0;
    r.rem    = '0;
    r.status = rrts_pkg::STAT_IDLE;
    found    = 1'b0;
    if (op == rrts_pkg::OP_ADD) begin
      if (ring_len >= rrts_pkg::MAX_PROCESSES) begin
        r.status = rrts_pkg::STAT_FULL;
      end else begin
        ring[ring_len].pid = pid;
        ring[ring_len].rem = etime;
        ring_len++;
        r.pid    = pid;
        r.rem    = etime;
        r.status = rrts_pkg::STAT_ADDED;
      end
    end else begin
      if (cursor >= ring_len) cursor = 0;
      // first nonzero entry from the cursor, wrapping at the ring length
      for (k = 0; k < ring_len; k++) begin
        slot = cursor + k;
        if (slot >= ring_len) slot -= ring_len;
        if (!found && ring[slot].rem != '0) begin
          found = 1'b1;
          if (ring[slot].rem <= quantum) begin
            ring[slot].rem = '0;
            r.status       = rrts_pkg::STAT_DONE;
          end else begin
            ring[slot].rem = ring[slot].rem - quantum;
            r.status       = rrts_pkg::STAT_RAN;
          end
          r.pid  = ring[slot].pid;
          r.rem  = ring[slot].rem;
          cursor = (slot + 1 >= ring_len) ? 0 : slot + 1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    slice_report_t want;
    slice_report_t got;
    if (!rst_n) begin
      ring_len    = 0;
      cursor      = 0;
      quantum     = 16'd1;
      mismatches  = 0;
      added_seen  = 0;
      full_seen   = 0;
      ran_seen    = 0;
      done_seen   = 0;
      idle_seen   = 0;
      awaited_reports.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.pid    = out_tdata[15:0];
        got.rem    = out_tdata[31:16];
        got.status = out_tuser;
        case (got.status)
          rrts_pkg::STAT_ADDED: added_seen++;
          rrts_pkg::STAT_FULL:  full_seen++;
          rrts_pkg::STAT_RAN:   ran_seen++;
          rrts_pkg::STAT_DONE:  done_seen++;
          rrts_pkg::STAT_IDLE:  idle_seen++;
          default:              ;
        endcase
        if (awaited_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result beat pid=%h rem=%h status=%0d",
                     $realtime, got.pid, got.rem, got.status);
        end else begin
          want = awaited_reports.pop_front();
          if (got.pid !== want.pid || got.rem !== want.rem || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch: pid %h/%h rem %h/%h status %0d/%0d (exp/act)",
                       $realtime, want.pid, got.pid, want.rem, got.rem,
                       want.status, got.status);
          end
        end
      end
      if (in_tvalid && in_tready)
        awaited_reports.push_back(schedule_item(in_tuser, in_tdata[15:0], in_tdata[31:16]));
      if (cfg_wr_en) quantum = cfg_wr_data;
    end
    outstanding = awaited_reports.size();
  end

endmodule

// File: verif/round_robin_time_slice_scheduler_tb.sv
`timescale 1ns / 1ps
// Top of the scheduler testbench: clock, reset, stimulus, stall patterns and verdict.
module round_robin_time_slice_scheduler_tb;

  localparam int CLK_PERIOD    = 12;
  localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
  localparam int SETTLE_CYCLES = 24;      // covers the longest serve
  localparam int HOLD_CYCLES   = 400;     // long output stall to back up the input

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;      // [15:0] process_id, [31:16] exec_time
  logic        in_tuser;      // [0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;     // [15:0] process_id_res, [31:16] remaining
  logic [2:0]  out_tuser;     // [2:0] status

  // Idle odds in percent, set per phase by the main sequence.
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;               // main sequence asks for the long stall
  bit hold_served;            // receiver has done it
  int cycle_count;
  int beats_sent;

  int mismatches;
  int outstanding;
  int added_seen;
  int full_seen;
  int ran_seen;
  int done_seen;
  int idle_seen;

  round_robin_time_slice_scheduler uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  round_robin_time_slice_scheduler_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .added_seen (added_seen),
    .full_seen  (full_seen),
    .ran_seen   (ran_seen),
    .done_seen  (done_seen),
    .idle_seen  (idle_seen)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Watchdog expired after %0d cycles, %0d results outstanding",
             cycle_count, outstanding);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side. out_tready is assigned on falling edges; the long stall
  // is counted here so the sender keeps offering beats meanwhile.
  initial begin : receiver
    int held;
    out_tready  = 1'b0;
    hold_served = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_served) begin
        out_tready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_served = 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offers one beat, with random idle cycles ahead of it, and returns on the
  // falling edge after it was taken. tvalid is assigned once per edge, so
  // back-to-back beats keep it high.
  task automatic send_beat(input logic op, input logic [15:0] pid,
                           input logic [15:0] etime);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {etime, pid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // Mostly serves; adds use short, near-maximum or fully random times so the
  // ring holds both quickly finishing and long-lived processes.
  task automatic random_beat(input int add_pct);
    logic [15:0] etime;
    case ($urandom_range(3))
      0:       etime = 16'($urandom_range(8));
      1:       etime = 16'hFFFF - 16'($urandom_range(15));
      default: etime = 16'($urandom);
    endcase
    if ($urandom_range(99) < add_pct) send_beat(rrts_pkg::OP_ADD, 16'($urandom), etime);
    else send_beat(rrts_pkg::OP_SERVE, 16'($urandom), 16'($urandom));
  endtask

  // Block is idle once every result is back and the longest scan has passed.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_quantum(input logic [15:0] q);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= q;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : main
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = rrts_pkg::OP_SERVE;
    hold_req    = 1'b0;
    beats_sent  = 0;
    tx_idle_pct = 35;
    rx_idle_pct = 58;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, at the reset quantum of 1.
    send_beat(rrts_pkg::OP_SERVE, 16'h0000, 16'h0000);   // empty ring: idle
    send_beat(rrts_pkg::OP_ADD,   16'h0000, 16'h0000);   // zero time, never pending
    send_beat(rrts_pkg::OP_SERVE, 16'hFFFF, 16'hFFFF);   // only a zero entry: idle
    send_beat(rrts_pkg::OP_ADD,   16'hFFFF, 16'hFFFF);
    send_beat(rrts_pkg::OP_ADD,   16'h1234, 16'h0001);   // completes on its first slice
    send_beat(rrts_pkg::OP_ADD,   16'h0001, 16'h0002);
    send_beat(rrts_pkg::OP_ADD,   16'h8000, 16'h0003);
    // five serves walk the ring once, skip the zero entry and wrap
    repeat (5) send_beat(rrts_pkg::OP_SERVE, 16'($urandom), 16'($urandom));

    // Zero quantum: served entries keep their time, cursor still moves.
    write_quantum(16'h0000);
    repeat (2) send_beat(rrts_pkg::OP_SERVE, 16'h0000, 16'h0000);

    // Random, small quantum; the ring fills early and the output is stalled
    // for a long stretch at the start of the phase.
    write_quantum(16'($urandom_range(40, 2)));
    hold_req = 1'b1;
    repeat (550) random_beat(12);

    // Swapped idle odds, mid-sized quantum.
    tx_idle_pct = 58;
    rx_idle_pct = 35;
    write_quantum(16'($urandom_range(300, 41)));
    repeat (550) random_beat(5);

    // No idling at all: large quantum, then the maximum to drain every entry
    // and end up serving an all-zero ring.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_quantum(16'($urandom_range(9000, 1000)));
    repeat (450) random_beat(5);
    write_quantum(16'hFFFF);
    repeat (90) random_beat(5);

    drain();
    $display("%0d beats: %0d added, %0d rejected full, %0d ran, %0d completed, %0d idle",
             beats_sent, added_seen, full_seen, ran_seen, done_seen, idle_seen);
    $display("Quanta 1, 0, small, mid, large and 65535; %0d-cycle output stall applied",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatching result beats", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
